// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the heap queue.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKHQ_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TKHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tkhq_pkg.sv =====
// Package of the two-key min-heap queue: field widths, entry type, codes.
// No dependencies.
`default_nettype none

package tkhq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W  = 2;
    localparam int PRIO_W = 8;
    localparam int LEN_W  = 16;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [LEN_W-1:0]  len;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/tkhq_ifs.sv =====
// Request and response channel interfaces of the heap queue.
// Depends on tkhq_pkg for field widths.
`default_nettype none

interface tkhq_req_if;
    logic                        valid;
    logic                        ready;
    logic [tkhq_pkg::CMD_W-1:0]  command;
    logic [tkhq_pkg::PRIO_W-1:0] priority_req;
    logic [tkhq_pkg::LEN_W-1:0]  length;
    logic [tkhq_pkg::TAG_W-1:0]  tag;

    modport source (output valid, command, priority_req, length, tag, input ready);
    modport sink   (input valid, command, priority_req, length, tag, output ready);
endinterface

interface tkhq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tkhq_pkg::STAT_W-1:0] status;
    logic                        head_valid;
    logic [tkhq_pkg::PRIO_W-1:0] head_priority;
    logic [tkhq_pkg::LEN_W-1:0]  head_length;
    logic [tkhq_pkg::TAG_W-1:0]  head_tag;
    logic [tkhq_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, status, head_valid, head_priority, head_length,
                    head_tag, occupancy, input ready);
    modport sink   (input valid, status, head_valid, head_priority, head_length,
                    head_tag, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/tkhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tkhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tkhq_rank_cmp.sv =====
// Shared two-key rank comparator: priority first, then length, smaller first.
// Depends on tkhq_pkg for the entry type.
`default_nettype none

module tkhq_rank_cmp (
    input  wire tkhq_pkg::entry_t a,
    input  wire tkhq_pkg::entry_t b,
    output      logic             a_first
);

    // Strict order: equal keys do not rank first.
    always_comb
    begin
        if (a.prio != b.prio)
        begin
            a_first = (a.prio < b.prio);
        end
        else
        begin
            a_first = (a.len < b.len);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/two_key_min_heap_queue_unit.sv =====
// Two-key binary min-heap priority queue: sequencer, heap RAM and shared comparator.
// Depends on tkhq_pkg, tkhq_ifs, tkhq_ram and tkhq_rank_cmp.
//
// Usage:
//   req carries one command per request: enqueue (priority_req, length, tag),
//   dequeue head, or clear. Commands are taken one at a time; req.ready is high
//   only while the sequencer idles. Every request gives exactly one response on
//   rsp: status (done, enqueue dropped because full, dequeue on empty), the head
//   entry after the command (zeros with head_valid low when empty) and occupancy.
// Sequence: clear, no-op, dropped enqueue, dequeue on empty or down to empty
//   go straight to the response. Enqueue climbs from the new tail slot: read
//   the parent, compare, move the parent down into the hole, until the entry no
//   longer ranks first or reaches the root. Dequeue reads the tail, then per level
//   reads the left child and the right child if present, picks the smaller and lifts
//   it while it ranks before the tail entry. With one read port and one comparator,
//   each level needs its reads issued and compared in turn.
// Reset: rst_n clears the entry count, the sequencer and the response valid;
//   heap RAM contents are not cleared, since only slots below the count are read.
// Stall: the response waits in an output register; the next request is taken
//   meanwhile, and its result holds in the sequencer until rsp is taken.
`default_nettype none

module two_key_min_heap_queue_unit #(
    parameter int CAPACITY = tkhq_pkg::CAPACITY_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tkhq_req_if.sink        req,
    tkhq_rsp_if.source      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int XW = (CW > tkhq_pkg::OCC_W) ? CW : tkhq_pkg::OCC_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_DN_TAIL  = 4'd3;
    localparam logic [3:0] S_DN_LEFT  = 4'd4;
    localparam logic [3:0] S_DN_RIGHT = 4'd5;
    localparam logic [3:0] S_DN_CHILD = 4'd6;
    localparam logic [3:0] S_DN_MOVE  = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    // Control state
    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // Working payload
    logic [AW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           pick_idx_reg, pick_idx_next;
    tkhq_pkg::entry_t        cur_reg, cur_next;
    tkhq_pkg::entry_t        left_reg, left_next;
    tkhq_pkg::entry_t        pick_reg, pick_next;
    tkhq_pkg::entry_t        head_reg;
    logic [tkhq_pkg::STAT_W-1:0] status_reg, status_next;

    // Response register
    logic [tkhq_pkg::STAT_W-1:0] out_status_reg;
    logic                        out_head_valid_reg;
    tkhq_pkg::entry_t            out_head_reg;
    logic [tkhq_pkg::OCC_W-1:0]  out_occ_reg;
    logic                        out_load;

    // RAM port and comparator
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    tkhq_pkg::entry_t        ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    tkhq_pkg::entry_t        ram_rdata;
    tkhq_pkg::entry_t        cmp_a, cmp_b;
    logic                    cmp_a_first;

    // Index arithmetic
    logic [AW-1:0]           pos_m1;
    logic [AW-1:0]           parent_idx;
    logic [IW-1:0]           left_idx;
    logic [IW-1:0]           right_idx;
    logic [IW-1:0]           cnt_ext;
    logic [CW-1:0]           cnt_m1;
    logic [XW-1:0]           cnt_x;
    logic                    req_fire;
    tkhq_pkg::entry_t        req_entry;

    tkhq_ram #(
        .WIDTH (tkhq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tkhq_rank_cmp u_rank_cmp (
        .a       (cmp_a),
        .b       (cmp_b),
        .a_first (cmp_a_first)
    );

    assign pos_m1     = pos_reg - AW'(1);
    assign parent_idx = AW'(pos_m1 >> 1);
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign cnt_ext    = IW'(cnt_reg);
    assign cnt_m1     = cnt_reg - CW'(1);
    assign cnt_x      = XW'(cnt_reg);

    assign req_fire  = req.valid && req.ready;
    assign req_entry = '{prio: req.priority_req, len: req.length, tag: req.tag};

    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    // Route the shared comparator by sequencer step.
    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = cur_reg;
                cmp_b = ram_rdata;
            end
            S_DN_CHILD:
            begin
                cmp_a = left_reg;
                cmp_b = ram_rdata;
            end
            default:
            begin
                cmp_a = pick_reg;
                cmp_b = cur_reg;
            end
        endcase
    end

    // Sequencer: the moving entry stays in cur_reg and is written once it settles.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        pick_idx_next = pick_idx_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        pick_next     = pick_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = cur_reg;
        ram_re        = 1'b0;
        ram_raddr     = parent_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    status_next = tkhq_pkg::STAT_DONE;
                    state_next  = S_FINISH;
                    case (req.command)
                        tkhq_pkg::CMD_ENQ:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                status_next = tkhq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cur_next   = req_entry;
                                pos_next   = cnt_reg[AW-1:0];
                                cnt_next   = cnt_reg + CW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        tkhq_pkg::CMD_DEQ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = tkhq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_m1;
                                if (cnt_m1 != '0)
                                begin
                                    // Fetch the tail entry to refill the root.
                                    ram_re     = 1'b1;
                                    ram_raddr  = cnt_m1[AW-1:0];
                                    state_next = S_DN_TAIL;
                                end
                            end
                        end
                        tkhq_pkg::CMD_CLR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            status_next = tkhq_pkg::STAT_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_a_first)
                begin
                    // Move the parent down into the hole and climb.
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DN_TAIL:
            begin
                cur_next   = ram_rdata;
                pos_next   = '0;
                state_next = S_DN_LEFT;
            end
            S_DN_LEFT:
            begin
                if (left_idx >= cnt_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = left_idx[AW-1:0];
                    state_next = S_DN_RIGHT;
                end
            end
            S_DN_RIGHT:
            begin
                left_next = ram_rdata;
                if (right_idx < cnt_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = right_idx[AW-1:0];
                    state_next = S_DN_CHILD;
                end
                else
                begin
                    pick_next     = ram_rdata;
                    pick_idx_next = left_idx[AW-1:0];
                    state_next    = S_DN_MOVE;
                end
            end
            S_DN_CHILD:
            begin
                // Equal children: take the right one.
                if (cmp_a_first)
                begin
                    pick_next     = left_reg;
                    pick_idx_next = left_idx[AW-1:0];
                end
                else
                begin
                    pick_next     = ram_rdata;
                    pick_idx_next = right_idx[AW-1:0];
                end
                state_next = S_DN_MOVE;
            end
            S_DN_MOVE:
            begin
                ram_we = 1'b1;
                if (cmp_a_first)
                begin
                    // Lift the smaller child into the hole and descend.
                    ram_wdata  = pick_reg;
                    pos_next   = pick_idx_reg;
                    state_next = S_DN_LEFT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drop the response valid once taken; raise it when a result is loaded.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        pick_idx_reg <= pick_idx_next;
        cur_reg      <= cur_next;
        left_reg     <= left_next;
        pick_reg     <= pick_next;
        status_reg   <= status_next;
        // Shadow the root slot so the head is at hand without a RAM read.
        if (ram_we && (ram_waddr == '0))
        begin
            head_reg <= ram_wdata;
        end
        if (out_load)
        begin
            out_status_reg     <= status_reg;
            out_head_valid_reg <= (cnt_reg != '0);
            out_head_reg       <= (cnt_reg != '0) ? head_reg : '0;
            out_occ_reg        <= cnt_x[tkhq_pkg::OCC_W-1:0];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.head_valid    = out_head_valid_reg;
    assign rsp.head_priority = out_head_reg.prio;
    assign rsp.head_length   = out_head_reg.len;
    assign rsp.head_tag      = out_head_reg.tag;
    assign rsp.occupancy     = out_occ_reg;

endmodule

`default_nettype wire

// ===== rtl/tkhq_checker.sv =====
// Port-level checker of the heap queue and its bind to the top level.
// Depends on assert_macros.svh and the top level two_key_min_heap_queue_unit.
`default_nettype none

`include "assert_macros.svh"

module tkhq_checker #(
    parameter int CAPACITY = tkhq_pkg::CAPACITY_DEF
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [tkhq_pkg::STAT_W-1:0] rsp_status,
    input wire logic                        rsp_head_valid,
    input wire logic [tkhq_pkg::PRIO_W-1:0] rsp_head_priority,
    input wire logic [tkhq_pkg::LEN_W-1:0]  rsp_head_length,
    input wire logic [tkhq_pkg::TAG_W-1:0]  rsp_head_tag,
    input wire logic [tkhq_pkg::OCC_W-1:0]  rsp_occupancy
);

    // Hold a stalled response unchanged.
    `TKHQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_head_valid) && $stable(rsp_head_priority) && $stable(rsp_head_length) && $stable(rsp_head_tag) && $stable(rsp_occupancy), "stalled response changed")

    // One request at a time: ready drops after a request is taken.
    `TKHQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")

    // Head valid tracks a nonzero occupancy.
    `TKHQ_ASSERT(a_head_occ, clk, rst_n, rsp_valid, (CAPACITY > 127) || (rsp_head_valid == (rsp_occupancy != '0)), "head valid disagrees with occupancy")

    // Empty queue reports a zero head.
    `TKHQ_ASSERT(a_empty_zero, clk, rst_n, rsp_valid && !rsp_head_valid, (rsp_head_priority == '0) && (rsp_head_length == '0) && (rsp_head_tag == '0), "empty head not zero")

    // Dropped enqueue only at full occupancy.
    `TKHQ_ASSERT(a_full_drop, clk, rst_n, rsp_valid && (rsp_status == tkhq_pkg::STAT_FULL), (CAPACITY > 127) || (rsp_occupancy == tkhq_pkg::OCC_W'(CAPACITY)), "drop below capacity")

endmodule

bind two_key_min_heap_queue_unit tkhq_checker #(
    .CAPACITY (CAPACITY)
) u_tkhq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_head_valid    (rsp.head_valid),
    .rsp_head_priority (rsp.head_priority),
    .rsp_head_length   (rsp.head_length),
    .rsp_head_tag      (rsp.head_tag),
    .rsp_occupancy     (rsp.occupancy)
);

`default_nettype wire
